// ===== rtl/core/lsss_pkg.sv =====
`default_nettype none

package lsss_pkg;

    localparam int WORDS_PER_SECTOR = 128;
    localparam int SLOT_COUNT       = 256;

    localparam int WORD_W = 32;
    localparam int TAG_W  = 16;
    localparam int IDX_W  = 7;

    localparam int WORD_AW    = (WORDS_PER_SECTOR > 1) ? $clog2(WORDS_PER_SECTOR) : 1;
    localparam int WCNT_W     = $clog2(WORDS_PER_SECTOR + 1);
    localparam int SLOT_AW    = $clog2(SLOT_COUNT);
    localparam int SLOT_CW    = $clog2(SLOT_COUNT + 1);
    localparam int DATA_DEPTH = SLOT_COUNT * WORDS_PER_SECTOR;
    localparam int DATA_AW    = $clog2(DATA_DEPTH);
    localparam int DPTR_W     = $clog2(DATA_DEPTH + 1);

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_STAGED  = 2'd1,
        ST_DROPPED = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
        logic               rd_en;
        logic [WORD_AW-1:0] rd_addr;
        logic               clear;
    } stage_cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] rd_data;
        logic              rd_valid;
        logic              nonzero;
    } stage_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/lsss_ram.sv =====
`default_nettype none

module lsss_ram #(
    parameter int  DEPTH = 2,
    parameter int  WIDTH = 1,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lsss_stage.sv =====
`default_nettype none

module lsss_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lsss_pkg::stage_cmd_t cmd,
    output lsss_pkg::stage_rsp_t     rsp
);

    logic [lsss_pkg::WORDS_PER_SECTOR-1:0] valid_reg;
    logic [lsss_pkg::WORDS_PER_SECTOR-1:0] valid_next;
    logic                                  nonzero_reg;
    logic                                  nonzero_next;
    logic                                  rd_valid_reg;
    logic [lsss_pkg::WORD_W-1:0]           rd_data;

    // Words that were not staged since the last clear read back with rd_valid low.
    lsss_ram #(
        .DEPTH (lsss_pkg::WORDS_PER_SECTOR),
        .WIDTH (lsss_pkg::WORD_W)
    ) u_stage_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (cmd.wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        valid_next   = valid_reg;
        nonzero_next = nonzero_reg;
        if (cmd.clear)
        begin
            valid_next   = '0;
            nonzero_next = 1'b0;
        end
        else if (cmd.wr_en)
        begin
            valid_next[cmd.wr_addr] = 1'b1;
            if (cmd.wr_data != '0)
            begin
                nonzero_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            nonzero_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            nonzero_reg <= nonzero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_valid_reg <= valid_reg[cmd.rd_addr];
        end
    end

    assign rsp.rd_data  = rd_data;
    assign rsp.rd_valid = rd_valid_reg;
    assign rsp.nonzero  = nonzero_reg;

endmodule

`default_nettype wire

// ===== rtl/core/log_structured_sector_store_core.sv =====
// Channel  Direction  Handshake          Payload
// in       to core    in_valid/in_stall  command, sector_number, word_index,
//                                        write_word, last_word
// out      from core  out_valid/out_stall read_word, status
//
// A staged write word, a dropped sector or a full store goes straight from the idle state to the done state.
// A commit copies the stage memory into the slot data memory, one word per cycle.
// A read scans the tag memory, newest slot first, one tag per cycle.
// Reset clears the slot count and the staged-word flags; no memory is swept.
// The core takes the next transfer while a finished result waits on a stalled output.
`default_nettype none

module log_structured_sector_store_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [15:0] sector_number,
    input  wire logic [6:0]  word_index,
    input  wire logic [31:0] write_word,
    input  wire logic        last_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      read_word,
    output logic [1:0]       status
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_FETCH  = 6'b000100,
        S_LOAD   = 6'b001000,
        S_COMMIT = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                           state_reg, state_next;
    logic [lsss_pkg::TAG_W-1:0]       tag_reg, tag_next;
    logic [lsss_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [lsss_pkg::SLOT_CW-1:0]     count_reg, count_next;
    logic [lsss_pkg::DPTR_W-1:0]      dptr_reg, dptr_next;
    logic [lsss_pkg::SLOT_AW-1:0]     scan_ptr_reg, scan_ptr_next;
    logic                             scan_more_reg, scan_more_next;
    logic                             cmp_vld_reg, cmp_vld_next;
    logic [lsss_pkg::SLOT_AW-1:0]     cmp_slot_reg, cmp_slot_next;
    logic [lsss_pkg::SLOT_AW-1:0]     found_reg, found_next;
    logic [lsss_pkg::WCNT_W-1:0]      sweep_reg, sweep_next;
    logic                             wr_pend_reg, wr_pend_next;
    logic [lsss_pkg::WORD_W-1:0]      res_word_reg, res_word_next;
    lsss_pkg::status_t                res_status_reg, res_status_next;
    logic                             out_valid_reg, out_valid_next;
    logic [lsss_pkg::WORD_W-1:0]      out_word_reg, out_word_next;
    lsss_pkg::status_t                out_status_reg, out_status_next;

    logic                             accept;
    logic                             in_range;
    logic                             nz_eff;
    logic                             full;
    logic                             rd_issue;

    lsss_pkg::stage_cmd_t             stage_cmd;
    lsss_pkg::stage_rsp_t             stage_rsp;

    logic                             tag_wr_en;
    logic                             tag_rd_en;
    logic [lsss_pkg::SLOT_AW-1:0]     tag_rd_addr;
    logic [lsss_pkg::TAG_W-1:0]       tag_rdata;

    logic                             data_wr_en;
    logic [lsss_pkg::WORD_W-1:0]      data_wr_data;
    logic                             data_rd_en;
    logic [lsss_pkg::DATA_AW-1:0]     data_rd_addr;
    logic [lsss_pkg::WORD_W-1:0]      data_rdata;

    lsss_stage u_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stage_cmd),
        .rsp   (stage_rsp)
    );

    lsss_ram #(
        .DEPTH (lsss_pkg::SLOT_COUNT),
        .WIDTH (lsss_pkg::TAG_W)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .wr_addr (lsss_pkg::SLOT_AW'(count_reg)),
        .wr_data (sector_number),
        .rd_en   (tag_rd_en),
        .rd_addr (tag_rd_addr),
        .rd_data (tag_rdata)
    );

    lsss_ram #(
        .DEPTH (lsss_pkg::DATA_DEPTH),
        .WIDTH (lsss_pkg::WORD_W)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (dptr_reg[lsss_pkg::DATA_AW-1:0]),
        .wr_data (data_wr_data),
        .rd_en   (data_rd_en),
        .rd_addr (data_rd_addr),
        .rd_data (data_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign in_range = 32'(word_index) < 32'(lsss_pkg::WORDS_PER_SECTOR);
    assign nz_eff   = stage_rsp.nonzero || (in_range && (write_word != '0));
    assign full     = (count_reg == lsss_pkg::SLOT_CW'(lsss_pkg::SLOT_COUNT));
    assign rd_issue = (sweep_reg < lsss_pkg::WCNT_W'(lsss_pkg::WORDS_PER_SECTOR));

    assign data_wr_data = stage_rsp.rd_valid ? stage_rsp.rd_data : '0;
    assign data_rd_addr = lsss_pkg::DATA_AW'(
        lsss_pkg::DATA_AW'(found_reg) * lsss_pkg::DATA_AW'(lsss_pkg::WORDS_PER_SECTOR)
        + lsss_pkg::DATA_AW'(idx_reg));

    always_comb
    begin
        state_next      = state_reg;
        tag_next        = tag_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        dptr_next       = dptr_reg;
        scan_ptr_next   = scan_ptr_reg;
        scan_more_next  = scan_more_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_slot_next   = cmp_slot_reg;
        found_next      = found_reg;
        sweep_next      = sweep_reg;
        wr_pend_next    = wr_pend_reg;
        res_word_next   = res_word_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        out_status_next = out_status_reg;

        stage_cmd         = '0;
        stage_cmd.wr_addr = lsss_pkg::WORD_AW'(word_index);
        stage_cmd.wr_data = write_word;
        stage_cmd.rd_addr = lsss_pkg::WORD_AW'(sweep_reg);

        tag_wr_en   = 1'b0;
        tag_rd_en   = 1'b0;
        tag_rd_addr = scan_ptr_reg;
        data_wr_en  = 1'b0;
        data_rd_en  = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tag_next      = sector_number;
                    idx_next      = word_index;
                    res_word_next = '0;
                    if (command == lsss_pkg::CMD_WRITE)
                    begin
                        stage_cmd.wr_en = in_range;
                        if (!last_word)
                        begin
                            res_status_next = lsss_pkg::ST_STAGED;
                            state_next      = S_DONE;
                        end
                        else if (!nz_eff)
                        begin
                            res_status_next = lsss_pkg::ST_DROPPED;
                            stage_cmd.clear = 1'b1;
                            state_next      = S_DONE;
                        end
                        else if (full)
                        begin
                            res_status_next = lsss_pkg::ST_FULL;
                            stage_cmd.clear = 1'b1;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            tag_wr_en    = 1'b1;
                            sweep_next   = '0;
                            wr_pend_next = 1'b0;
                            state_next   = S_COMMIT;
                        end
                    end
                    else
                    begin
                        res_status_next = lsss_pkg::ST_OK;
                        if (!in_range || (count_reg == '0))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            scan_ptr_next  = lsss_pkg::SLOT_AW'(count_reg - 1'b1);
                            scan_more_next = 1'b1;
                            cmp_vld_next   = 1'b0;
                            state_next     = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                tag_rd_en     = scan_more_reg;
                cmp_vld_next  = scan_more_reg;
                cmp_slot_next = scan_ptr_reg;
                if (scan_more_reg)
                begin
                    if (scan_ptr_reg == '0)
                    begin
                        scan_more_next = 1'b0;
                    end
                    else
                    begin
                        scan_ptr_next = scan_ptr_reg - 1'b1;
                    end
                end
                if (cmp_vld_reg && (tag_rdata == tag_reg))
                begin
                    found_next = cmp_slot_reg;
                    state_next = S_FETCH;
                end
                else if (!cmp_vld_reg && !scan_more_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_FETCH:
            begin
                data_rd_en = 1'b1;
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                res_word_next = data_rdata;
                state_next    = S_DONE;
            end

            S_COMMIT:
            begin
                stage_cmd.rd_en = rd_issue;
                wr_pend_next    = rd_issue;
                if (rd_issue)
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
                if (wr_pend_reg)
                begin
                    data_wr_en = 1'b1;
                    dptr_next  = dptr_reg + 1'b1;
                end
                if (!rd_issue && !wr_pend_reg)
                begin
                    stage_cmd.clear = 1'b1;
                    count_next      = count_reg + 1'b1;
                    res_status_next = lsss_pkg::ST_OK;
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_word_next   = res_word_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dptr_reg      <= '0;
            scan_more_reg <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            sweep_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dptr_reg      <= dptr_next;
            scan_more_reg <= scan_more_next;
            cmp_vld_reg   <= cmp_vld_next;
            sweep_reg     <= sweep_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg        <= tag_next;
        idx_reg        <= idx_next;
        scan_ptr_reg   <= scan_ptr_next;
        cmp_slot_reg   <= cmp_slot_next;
        found_reg      <= found_next;
        res_word_reg   <= res_word_next;
        res_status_reg <= res_status_next;
        out_word_reg   <= out_word_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid = out_valid_reg;
    assign read_word = out_word_reg;
    assign status    = out_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lsss_pkg::SLOT_CW'(lsss_pkg::SLOT_COUNT))
        else $error("slot count beyond the number of slots");

    a_tag_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        tag_wr_en |-> !full)
        else $error("tag written into a full store");

    a_dptr_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
            (dptr_reg == lsss_pkg::DPTR_W'(32'(count_reg) * lsss_pkg::WORDS_PER_SECTOR)))
        else $error("data write pointer out of step with slot count");

    a_commit_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT && state_next == S_DONE) |=>
            (count_reg == lsss_pkg::SLOT_CW'($past(count_reg) + 1'b1)))
        else $error("commit finished without claiming a slot");
`endif

endmodule

`default_nettype wire
